>>> sv/cpulm_pkg.sv
// shared types and constants for the cpu load monitor
package cpulm_pkg;

  localparam int CPU_W      = 7;
  localparam int IO_W       = 10;
  localparam int CPU_REL_W  = 14;
  localparam int IO_REL_W   = 17;
  localparam int MIN_INT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int QUO_W      = 17;
  localparam int STEP_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CPU = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT = 2'd2;

  localparam logic [CPU_REL_W-1:0] MAX_CPU_RST = 14'd100;
  localparam logic [IO_REL_W-1:0]  MAX_IO_RST  = 17'd50;
  localparam logic [MIN_INT_W-1:0] MIN_INT_RST = 16'd500;

  localparam logic [CPU_REL_W-1:0] CPU_REL_SAT = 14'd10000;
  localparam logic [IO_REL_W-1:0]  IO_REL_SAT  = 17'd100000;
  localparam logic [QUO_W-1:0]     REL_SCALE   = 17'd100;

  localparam logic [STEP_W-1:0] CPU_Q_STEPS = 5'd7;
  localparam logic [STEP_W-1:0] IO_Q_STEPS  = 5'd10;
  localparam logic [STEP_W-1:0] REL_STEPS   = 5'd17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DELTA_GO,
    ST_DELTA_WAIT,
    ST_DCPU_GO,
    ST_DCPU_WAIT,
    ST_DIO_GO,
    ST_DIO_WAIT,
    ST_RCPU_GO,
    ST_RCPU_WAIT,
    ST_RIO_GO,
    ST_RIO_WAIT,
    ST_DONE
  } cpulm_state_t;

endpackage

>>> sv/cpu_load_monitor_ema_unit.sv
// cpu and io load monitor with exponential smoothing, top level
// One transaction in gives one transaction out. A sample that is ignored by
// the interval test, or that is invalid, goes through the interval test, two
// 17-step divisions that scale the smoothed loads by the configured maxima,
// and the load of the output register. A valid sample that is taken adds,
// before the scaling divisions, a bit-serial pass over the stored counters
// of COUNTER_BITS + 10 steps; when a previous sample is stored and the total
// delta is nonzero, two more divisions of 7 and 10 steps follow that pass.
// The block takes one transaction at a time and accepts the next input in
// the cycle after the result is loaded. The result sits in an output
// register while it waits; a finished result stalls the block until that
// register is free. Configuration writes are accepted in every cycle.
module cpu_load_monitor_ema_unit #(
  parameter int COUNTER_BITS = 48,
  parameter int TIME_BITS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COUNTER_BITS-1:0]          in_user_ticks,
  input  logic [COUNTER_BITS-1:0]          in_system_ticks,
  input  logic [COUNTER_BITS-1:0]          in_nice_ticks,
  input  logic [COUNTER_BITS-1:0]          in_idle_ticks,
  input  logic [COUNTER_BITS-1:0]          in_iowait_ticks,
  input  logic                             in_sample_valid,
  input  logic [TIME_BITS-1:0]             in_now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_cpu_known,
  output logic [cpulm_pkg::CPU_REL_W-1:0]  out_cpu_load_rel,
  output logic                             out_io_known,
  output logic [cpulm_pkg::IO_REL_W-1:0]   out_io_load_rel,
  output logic                             out_sample_taken,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cpulm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpulm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cpulm_pkg::*;

  localparam int CB = COUNTER_BITS;
  localparam int PW = CB + 10;
  localparam int DW = (CB + 12 > 34) ? CB + 12 : 34;

  cpulm_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0] now_r, last_time_r, last_time_nxt, elapsed;
  logic                 svalid_r, have_last_r, have_last_nxt;
  logic                 taken_r, taken_nxt, taken_c;
  logic [CPU_W-1:0]     sm_cpu_r, sm_cpu_nxt, cur_cpu_r, cur_cpu_nxt;
  logic [IO_W-1:0]      sm_io_r, sm_io_nxt;
  logic                 sm_cpu_known_r, sm_cpu_known_nxt;
  logic                 sm_io_known_r, sm_io_known_nxt;
  logic [CPU_REL_W-1:0] rel_cpu_r, rel_cpu_nxt, max_cpu_r;
  logic [IO_REL_W-1:0]  rel_io_r, rel_io_nxt, max_io_r;
  logic [MIN_INT_W-1:0] min_int_r;
  logic [CPU_W+4:0]     cpu_mix;
  logic [IO_W+4:0]      io_mix;

  logic                 accept, out_load, out_valid_r;
  logic                 dly_start, dly_done, dly_nz;
  logic [PW-1:0]        prod_cpu, prod_io;
  logic [CB+2:0]        total;

  logic                 div_start, div_done;
  logic [DW-1:0]        div_num, div_den;
  logic [STEP_W-1:0]    div_steps;
  logic [QUO_W-1:0]     div_quo;

  cpulm_delta #(.CB(CB)) u_delta (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap_en   (accept),
    .ctr_i    ({in_iowait_ticks, in_idle_ticks, in_nice_ticks,
                in_system_ticks, in_user_ticks}),
    .start    (dly_start),
    .done     (dly_done),
    .prod_cpu (prod_cpu),
    .prod_io  (prod_io),
    .total    (total),
    .total_nz (dly_nz)
  );

  cpulm_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign elapsed = now_r - last_time_r;
  assign taken_c = !sm_cpu_known_r || (elapsed > TIME_BITS'(min_int_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (accept) state_nxt = ST_CHECK;
      ST_CHECK:      state_nxt = (taken_c && svalid_r) ? ST_DELTA_GO : ST_RCPU_GO;
      ST_DELTA_GO:   state_nxt = ST_DELTA_WAIT;
      ST_DELTA_WAIT: begin
        if (dly_done) state_nxt = (dly_nz && have_last_r) ? ST_DCPU_GO : ST_RCPU_GO;
      end
      ST_DCPU_GO:    state_nxt = ST_DCPU_WAIT;
      ST_DCPU_WAIT:  if (div_done) state_nxt = ST_DIO_GO;
      ST_DIO_GO:     state_nxt = ST_DIO_WAIT;
      ST_DIO_WAIT:   if (div_done) state_nxt = ST_RCPU_GO;
      ST_RCPU_GO:    state_nxt = ST_RCPU_WAIT;
      ST_RCPU_WAIT:  if (div_done) state_nxt = ST_RIO_GO;
      ST_RIO_GO:     state_nxt = ST_RIO_WAIT;
      ST_RIO_WAIT:   if (div_done) state_nxt = ST_DONE;
      ST_DONE:       if (out_load) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    dly_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    div_num   = DW'(prod_cpu);
    div_den   = DW'(total) << (CPU_Q_STEPS - STEP_W'(1));
    div_steps = CPU_Q_STEPS;
    unique case (state_r)
      ST_IDLE:     in_ready = 1'b1;
      ST_DELTA_GO: dly_start = 1'b1;
      ST_DCPU_GO:  div_start = 1'b1;
      ST_DIO_GO: begin
        div_start = 1'b1;
        div_num   = DW'(prod_io);
        div_den   = DW'(total) << (IO_Q_STEPS - STEP_W'(1));
        div_steps = IO_Q_STEPS;
      end
      ST_RCPU_GO: begin
        div_start = 1'b1;
        div_num   = DW'(QUO_W'(sm_cpu_r) * REL_SCALE);
        div_den   = DW'(max_cpu_r) << (REL_STEPS - STEP_W'(1));
        div_steps = REL_STEPS;
      end
      ST_RIO_GO: begin
        div_start = 1'b1;
        div_num   = DW'(QUO_W'(sm_io_r) * REL_SCALE);
        div_den   = DW'(max_io_r) << (REL_STEPS - STEP_W'(1));
        div_steps = REL_STEPS;
      end
      ST_DONE:     out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // datapath next values
  always_comb begin
    last_time_nxt    = last_time_r;
    have_last_nxt    = have_last_r;
    taken_nxt        = taken_r;
    cur_cpu_nxt      = cur_cpu_r;
    sm_cpu_nxt       = sm_cpu_r;
    sm_io_nxt        = sm_io_r;
    sm_cpu_known_nxt = sm_cpu_known_r;
    sm_io_known_nxt  = sm_io_known_r;
    rel_cpu_nxt      = rel_cpu_r;
    rel_io_nxt       = rel_io_r;
    cpu_mix = {sm_cpu_r, 5'b00000} - {5'b00000, sm_cpu_r} + {5'b00000, cur_cpu_r};
    io_mix  = {sm_io_r, 5'b00000} - {5'b00000, sm_io_r} + {5'b00000, div_quo[IO_W-1:0]};
    case (state_r)
      ST_CHECK: begin
        taken_nxt = taken_c;
        if (taken_c) begin
          last_time_nxt = now_r;
          if (!svalid_r) begin
            have_last_nxt    = 1'b0;
            sm_cpu_known_nxt = 1'b0;
            sm_io_known_nxt  = 1'b0;
            sm_cpu_nxt       = '0;
            sm_io_nxt        = '0;
          end
        end
      end
      ST_DELTA_WAIT: begin
        if (dly_done) begin
          have_last_nxt = 1'b1;
          if (!(dly_nz && have_last_r)) begin
            sm_cpu_known_nxt = 1'b0;
            sm_io_known_nxt  = 1'b0;
            sm_cpu_nxt       = '0;
            sm_io_nxt        = '0;
          end
        end
      end
      ST_DCPU_WAIT: if (div_done) cur_cpu_nxt = div_quo[CPU_W-1:0];
      ST_DIO_WAIT: begin
        if (div_done) begin
          sm_cpu_nxt       = sm_cpu_known_r ? cpu_mix[CPU_W+4:5] : cur_cpu_r;
          sm_io_nxt        = sm_io_known_r ? io_mix[IO_W+4:5] : div_quo[IO_W-1:0];
          sm_cpu_known_nxt = 1'b1;
          sm_io_known_nxt  = 1'b1;
        end
      end
      ST_RCPU_WAIT: if (div_done) rel_cpu_nxt = div_quo[CPU_REL_W-1:0];
      ST_RIO_WAIT:  if (div_done) rel_io_nxt = div_quo[IO_REL_W-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      last_time_r    <= '0;
      have_last_r    <= 1'b0;
      sm_cpu_r       <= '0;
      sm_io_r        <= '0;
      sm_cpu_known_r <= 1'b0;
      sm_io_known_r  <= 1'b0;
      out_valid_r    <= 1'b0;
      max_cpu_r      <= MAX_CPU_RST;
      max_io_r       <= MAX_IO_RST;
      min_int_r      <= MIN_INT_RST;
    end else begin
      state_r        <= state_nxt;
      last_time_r    <= last_time_nxt;
      have_last_r    <= have_last_nxt;
      sm_cpu_r       <= sm_cpu_nxt;
      sm_io_r        <= sm_io_nxt;
      sm_cpu_known_r <= sm_cpu_known_nxt;
      sm_io_known_r  <= sm_io_known_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_CPU: max_cpu_r <= cfg_data[CPU_REL_W-1:0];
          CFG_MAX_IO:  max_io_r  <= cfg_data[IO_REL_W-1:0];
          CFG_MIN_INT: min_int_r <= cfg_data[MIN_INT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r    <= in_now_ms;
      svalid_r <= in_sample_valid;
    end
    taken_r   <= taken_nxt;
    cur_cpu_r <= cur_cpu_nxt;
    rel_cpu_r <= rel_cpu_nxt;
    rel_io_r  <= rel_io_nxt;
    if (out_load) begin
      out_cpu_known    <= sm_cpu_known_r;
      out_io_known     <= sm_io_known_r;
      out_sample_taken <= taken_r;
      out_cpu_load_rel <= !sm_cpu_known_r ? '0 :
                          (max_cpu_r == '0) ? CPU_REL_SAT : rel_cpu_r;
      out_io_load_rel  <= !sm_io_known_r ? '0 :
                          (max_io_r == '0) ? IO_REL_SAT : rel_io_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/cpulm_delta.sv
// bit-serial counter deltas, sums and constant products, with stored counters
module cpulm_delta #(
  parameter int CB = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cap_en,
  input  logic [4:0][CB-1:0]  ctr_i,
  input  logic                start,
  output logic                done,
  output logic [CB+9:0]       prod_cpu,
  output logic [CB+9:0]       prod_io,
  output logic [CB+2:0]       total,
  output logic                total_nz
);

  localparam int PW   = CB + 10;
  localparam int CNTW = $clog2(PW + 1);

  logic [4:0][CB-1:0] new_r, last_r;
  logic [4:0]         brw_r;
  logic [1:0]         cu_r, ct_r, cp_r;
  logic [2:0]         ci_r;
  logic [5:0]         uh_r;
  logic [8:0]         dh_r;
  logic [PW-1:0]      acc_cpu_r, acc_io_r, acc_tot_r;
  logic               nz_r, busy_r, done_r;
  logic [CNTW-1:0]    cnt_r;

  logic               in_ctr;
  logic [4:0]         d, brw_nxt;
  logic [2:0]         usum, tsum, psum;
  logic [3:0]         isum;

  always_comb begin
    in_ctr = busy_r && (cnt_r < CNTW'(CB));
    for (int i = 0; i < 5; i++) begin
      d[i]       = in_ctr & (new_r[i][0] ^ last_r[i][0] ^ brw_r[i]);
      brw_nxt[i] = (~new_r[i][0] & last_r[i][0]) | (~new_r[i][0] & brw_r[i])
                 | (last_r[i][0] & brw_r[i]);
    end
    usum = {2'b00, d[0]} + {2'b00, d[1]} + {2'b00, d[2]} + {1'b0, cu_r};
    tsum = {2'b00, usum[0]} + {2'b00, d[3]} + {2'b00, d[4]} + {1'b0, ct_r};
    // 100 = 64 + 32 + 4
    psum = {2'b00, uh_r[1]} + {2'b00, uh_r[4]} + {2'b00, uh_r[5]} + {1'b0, cp_r};
    // 1000 = 512 + 256 + 128 + 64 + 32 + 8
    isum = {3'b000, dh_r[2]} + {3'b000, dh_r[4]} + {3'b000, dh_r[5]}
         + {3'b000, dh_r[6]} + {3'b000, dh_r[7]} + {3'b000, dh_r[8]}
         + {1'b0, ci_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(PW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        if (in_ctr) begin
          for (int i = 0; i < 5; i++) begin
            last_r[i] <= {new_r[i][0], last_r[i][CB-1:1]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      new_r <= ctr_i;
    end else if (in_ctr) begin
      for (int i = 0; i < 5; i++) begin
        new_r[i] <= new_r[i] >> 1;
      end
    end
    if (start) begin
      brw_r <= '0;
      cu_r  <= '0;
      ct_r  <= '0;
      cp_r  <= '0;
      ci_r  <= '0;
      uh_r  <= '0;
      dh_r  <= '0;
      nz_r  <= 1'b0;
    end else if (busy_r) begin
      brw_r     <= brw_nxt;
      cu_r      <= usum[2:1];
      ct_r      <= tsum[2:1];
      cp_r      <= psum[2:1];
      ci_r      <= isum[3:1];
      uh_r      <= {uh_r[4:0], usum[0]};
      dh_r      <= {dh_r[7:0], d[4]};
      nz_r      <= nz_r | tsum[0];
      acc_cpu_r <= {psum[0], acc_cpu_r[PW-1:1]};
      acc_io_r  <= {isum[0], acc_io_r[PW-1:1]};
      acc_tot_r <= {tsum[0], acc_tot_r[PW-1:1]};
    end
  end

  assign done     = done_r;
  assign prod_cpu = acc_cpu_r;
  assign prod_io  = acc_io_r;
  assign total    = acc_tot_r[CB+2:0];
  assign total_nz = nz_r;

endmodule

>>> sv/cpulm_div.sv
// restoring divider, one quotient bit per cycle
module cpulm_div #(
  parameter int DW = 60
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DW-1:0]                num,
  input  logic [DW-1:0]                den,
  input  logic [cpulm_pkg::STEP_W-1:0] steps,
  output logic                         done,
  output logic [cpulm_pkg::QUO_W-1:0]  quo
);
  import cpulm_pkg::*;

  logic [DW-1:0]     rem_r, den_r, diff;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r, ge;

  assign ge   = rem_r >= den_r;
  assign diff = rem_r - den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff : rem_r;
      den_r <= den_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
